[src/rbst_pkg.sv]
`timescale 1ns / 1ps
// rbst_pkg: shared widths, types, register indexes and saturation helper
// for the ray/box slab test; no dependencies
package rbst_pkg;

   parameter int COORD_WIDTH = 32;
   parameter int FRAC_BITS   = 16;
   parameter int PROD_WIDTH  = 2 * COORD_WIDTH;
   parameter int QUOT_WIDTH  = PROD_WIDTH - FRAC_BITS;
   parameter int SUM_WIDTH   = QUOT_WIDTH + 1;
   parameter int AXES        = 3;
   parameter int NUM_STAGES  = 5;
   parameter int NUM_REGS    = 6;
   parameter int CSR_IDX_WIDTH = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [QUOT_WIDTH-1:0]  quot_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [CSR_IDX_WIDTH-1:0]      csr_idx_type;

   typedef struct packed {
      coord_type scale;
      coord_type offset;
   } axis_cfg_type;

   localparam csr_idx_type REG_SCALE_X  = CSR_IDX_WIDTH'(0);
   localparam csr_idx_type REG_SCALE_Y  = CSR_IDX_WIDTH'(1);
   localparam csr_idx_type REG_SCALE_Z  = CSR_IDX_WIDTH'(2);
   localparam csr_idx_type REG_OFFSET_X = CSR_IDX_WIDTH'(3);
   localparam csr_idx_type REG_OFFSET_Y = CSR_IDX_WIDTH'(4);
   localparam csr_idx_type REG_OFFSET_Z = CSR_IDX_WIDTH'(5);

   localparam coord_type SCALE_RESET  = COORD_WIDTH'(1) << FRAC_BITS;
   localparam coord_type OFFSET_RESET = '0;

   // clamp a wide signed sum into the coordinate range
   function automatic coord_type sat_coord(input sum_type s);
      logic sgn;
      logic fits;
      sgn  = s[SUM_WIDTH-1];
      fits = (s[SUM_WIDTH-1:COORD_WIDTH-1] == {(SUM_WIDTH-COORD_WIDTH+1){sgn}});
      if (fits) begin
         return s[COORD_WIDTH-1:0];
      end
      return {sgn, {(COORD_WIDTH-1){~sgn}}};
   endfunction

endpackage

[src/rbst_if.sv]
`timescale 1ns / 1ps
// rbst channel interfaces: request, response and register write channels
// depends on rbst_pkg
interface rbst_req_if;
   import rbst_pkg::*;
   logic      valid;
   logic      ready;
   coord_type box_min_x;
   coord_type box_min_y;
   coord_type box_min_z;
   coord_type box_max_x;
   coord_type box_max_y;
   coord_type box_max_z;
   coord_type depth_limit;

   modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x,
                   box_max_y, box_max_z, depth_limit, input ready);
   modport sink   (input valid, box_min_x, box_min_y, box_min_z, box_max_x,
                   box_max_y, box_max_z, depth_limit, output ready);
endinterface

interface rbst_rsp_if;
   import rbst_pkg::*;
   logic      valid;
   logic      ready;
   logic      hit;
   coord_type t_entry;
   coord_type t_exit;

   modport source (output valid, hit, t_entry, t_exit, input ready);
   modport sink   (input valid, hit, t_entry, t_exit, output ready);
endinterface

interface rbst_csr_if;
   import rbst_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   coord_type   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/rbst_csr.sv]
`timescale 1ns / 1ps
// rbst_csr: ray scale and offset registers per axis
// depends on rbst_pkg
module rbst_csr
   import rbst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  csr_idx_type  wr_index,
   input  coord_type    wr_data,
   output axis_cfg_type cfg [AXES]
);

   axis_cfg_type cfg_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            cfg_ff[a].scale  <= SCALE_RESET;
            cfg_ff[a].offset <= OFFSET_RESET;
         end
      end else if (wr_en) begin
         unique case (wr_index)
            REG_SCALE_X:  cfg_ff[0].scale  <= wr_data;
            REG_SCALE_Y:  cfg_ff[1].scale  <= wr_data;
            REG_SCALE_Z:  cfg_ff[2].scale  <= wr_data;
            REG_OFFSET_X: cfg_ff[0].offset <= wr_data;
            REG_OFFSET_Y: cfg_ff[1].offset <= wr_data;
            REG_OFFSET_Z: cfg_ff[2].offset <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/rbst_axis.sv]
`timescale 1ns / 1ps
// rbst_axis: one axis slab, three stages (multiply, shift/offset/saturate,
// near/far sort); depends on rbst_pkg
module rbst_axis
   import rbst_pkg::*;
(
   input  logic         clock,
   input  logic         advance,
   input  axis_cfg_type cfg,
   input  coord_type    box_min,
   input  coord_type    box_max,
   output coord_type    near_t,
   output coord_type    far_t
);

   coord_type scale;
   coord_type offset;
   prod_type  prod_min_in, prod_max_in, prod_min_ff, prod_max_ff;
   quot_type  quot_min, quot_max;
   coord_type t_min_in, t_max_in, t_min_ff, t_max_ff;
   coord_type near_in, far_in, near_ff, far_ff;

   assign scale  = cfg.scale;
   assign offset = cfg.offset;

   // stage 1: full signed products
   assign prod_min_in = PROD_WIDTH'(box_min) * PROD_WIDTH'(scale);
   assign prod_max_in = PROD_WIDTH'(box_max) * PROD_WIDTH'(scale);

   // stage 2: floor shift, add offset, saturate
   assign quot_min = QUOT_WIDTH'(prod_min_ff >>> FRAC_BITS);
   assign quot_max = QUOT_WIDTH'(prod_max_ff >>> FRAC_BITS);
   assign t_min_in = sat_coord(SUM_WIDTH'(quot_min) + SUM_WIDTH'(offset));
   assign t_max_in = sat_coord(SUM_WIDTH'(quot_max) + SUM_WIDTH'(offset));

   // stage 3: order the two crossings
   assign near_in = (t_min_ff < t_max_ff) ? t_min_ff : t_max_ff;
   assign far_in  = (t_min_ff < t_max_ff) ? t_max_ff : t_min_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_min_ff <= prod_min_in;
         prod_max_ff <= prod_max_in;
         t_min_ff    <= t_min_in;
         t_max_ff    <= t_max_in;
         near_ff     <= near_in;
         far_ff      <= far_in;
      end
   end

   assign near_t = near_ff;
   assign far_t  = far_ff;

endmodule

[src/rbst_reduce.sv]
`timescale 1ns / 1ps
// rbst_reduce: combines the per-axis intervals into entry/exit and the hit flag
// two stages; depends on rbst_pkg
module rbst_reduce
   import rbst_pkg::*;
(
   input  logic      clock,
   input  logic      advance,
   input  coord_type near_t [AXES],
   input  coord_type far_t  [AXES],
   input  coord_type depth,
   output logic      hit,
   output coord_type t_entry,
   output coord_type t_exit
);

   coord_type entry_in, exit_in, entry_ff, exit_ff;
   coord_type out_entry_ff, out_exit_ff;
   logic      hit_in, hit_ff;

   always_comb begin
      entry_in = near_t[0];
      exit_in  = far_t[0];
      for (int a = 1; a < AXES; a++) begin
         if (near_t[a] > entry_in) begin
            entry_in = near_t[a];
         end
         if (far_t[a] < exit_in) begin
            exit_in = far_t[a];
         end
      end
      if (depth < exit_in) begin
         exit_in = depth;
      end
   end

   assign hit_in = (entry_ff <= exit_ff) && (exit_ff > 0);

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff     <= entry_in;
         exit_ff      <= exit_in;
         hit_ff       <= hit_in;
         out_entry_ff <= entry_ff;
         out_exit_ff  <= exit_ff;
      end
   end

   assign hit     = hit_ff;
   assign t_entry = out_entry_ff;
   assign t_exit  = out_exit_ff;

endmodule

[src/ray_box_slab_test.sv]
`timescale 1ns / 1ps
// ray_box_slab_test: top level, streaming ray versus axis-aligned box test
// depends on rbst_pkg, rbst_if, rbst_csr, rbst_axis, rbst_reduce

// A five-stage pipeline that takes one box request per clock while the output
// register is empty or being taken, and returns one result per request, in
// order. Stages: (1) six 32x32 signed products of the box
// corners with the per-axis scale, (2) floor shift by the fraction bits, add
// the per-axis offset and saturate, (3) near/far sort per axis, (4) entry as
// the largest near, exit as the smallest far capped by depth_limit, (5) hit
// flag and output register. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so a stalled
// response holds every stage and nothing is dropped or repeated. Ray scale
// and offset registers are written through the csr channel (always ready,
// indexes past the last register are ignored) and must only change while no
// request is in flight.
module ray_box_slab_test
   import rbst_pkg::*;
(
   input logic      clock,
   input logic      reset,
   rbst_req_if.sink   req_if,
   rbst_rsp_if.source rsp_if,
   rbst_csr_if.sink   csr_if
);

   axis_cfg_type cfg [AXES];
   coord_type    box_min [AXES];
   coord_type    box_max [AXES];
   coord_type    near_t  [AXES];
   coord_type    far_t   [AXES];

   // valid bit per stage, stage NUM_STAGES-1 is the output register
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic                  advance;

   // depth limit rides alongside the three axis stages
   coord_type depth_s1_ff, depth_s2_ff, depth_s3_ff;

   // register writes
   assign csr_if.ready = 1'b1;

   rbst_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   // pipeline moves when the output slot is free or being drained
   assign advance      = !valid_ff[NUM_STAGES-1] || rsp_if.ready;
   assign req_if.ready = advance;

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         depth_s1_ff <= req_if.depth_limit;
         depth_s2_ff <= depth_s1_ff;
         depth_s3_ff <= depth_s2_ff;
      end
   end

   // request corners per axis
   assign box_min[0] = req_if.box_min_x;
   assign box_min[1] = req_if.box_min_y;
   assign box_min[2] = req_if.box_min_z;
   assign box_max[0] = req_if.box_max_x;
   assign box_max[1] = req_if.box_max_y;
   assign box_max[2] = req_if.box_max_z;

   // one slab unit per axis, stages 1 to 3
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      rbst_axis u_axis (
         .clock   (clock),
         .advance (advance),
         .cfg     (cfg[a]),
         .box_min (box_min[a]),
         .box_max (box_max[a]),
         .near_t  (near_t[a]),
         .far_t   (far_t[a])
      );
   end

   // stages 4 and 5
   rbst_reduce u_reduce (
      .clock   (clock),
      .advance (advance),
      .near_t  (near_t),
      .far_t   (far_t),
      .depth   (depth_s3_ff),
      .hit     (rsp_if.hit),
      .t_entry (rsp_if.t_entry),
      .t_exit  (rsp_if.t_exit)
   );

   assign rsp_if.valid = valid_ff[NUM_STAGES-1];

endmodule

[src/rbst_checker.sv]
`timescale 1ns / 1ps
// rbst_checker: port-level assertions for ray_box_slab_test, bound to the top
// depends on rbst_pkg
module rbst_checker
   import rbst_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      rsp_hit,
   input coord_type rsp_t_entry,
   input coord_type rsp_t_exit
);

   // response stays up while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled payload does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_hit) && $stable(rsp_t_entry) && $stable(rsp_t_exit))
      else $error("response payload changed while stalled");

   // hit flag agrees with the reported interval
   a_hit_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit == ((rsp_t_entry <= rsp_t_exit) && (rsp_t_exit > 0)))
      else $error("hit flag disagrees with entry/exit");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_hit     (rsp_if.hit),
   .rsp_t_entry (rsp_if.t_entry),
   .rsp_t_exit  (rsp_if.t_exit)
);
